// ===== sv/hidks1_pkg.sv =====
package hidks1_pkg;

  localparam int NumSlots  = 6;
  localparam int NumMods   = 8;
  localparam int NumEvents = NumMods + 2 * NumSlots;
  localparam int RelBase   = NumMods;
  localparam int PressBase = NumMods + NumSlots;
  localparam int EvIdxW    = $clog2(NumEvents);
  localparam int RomSize   = 96;

  localparam logic [7:0] RomFirst = 8'h04;
  localparam logic [7:0] RomLast  = 8'h63;
  localparam logic [7:0] BreakBit = 8'h80;
  localparam logic [7:0] ErrFirst = 8'h01;
  localparam logic [7:0] ErrLast  = 8'h03;

  // Bit 8 of each entry marks a code that needs the extended prefix
  localparam logic [8:0] UsageRom [RomSize] = '{
    9'h01e, 9'h030, 9'h02e, 9'h020, 9'h012, 9'h021, 9'h022, 9'h023,
    9'h017, 9'h024, 9'h025, 9'h026, 9'h032, 9'h031, 9'h018, 9'h019,
    9'h010, 9'h013, 9'h01f, 9'h014, 9'h016, 9'h02f, 9'h011, 9'h02d,
    9'h015, 9'h02c, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006, 9'h007,
    9'h008, 9'h009, 9'h00a, 9'h00b, 9'h01c, 9'h001, 9'h00e, 9'h00f,
    9'h039, 9'h00c, 9'h00d, 9'h01a, 9'h01b, 9'h02b, 9'h02b, 9'h027,
    9'h028, 9'h029, 9'h033, 9'h034, 9'h035, 9'h03a, 9'h03b, 9'h03c,
    9'h03d, 9'h03e, 9'h03f, 9'h040, 9'h041, 9'h042, 9'h043, 9'h044,
    9'h057, 9'h058, 9'h137, 9'h046, 9'h145, 9'h152, 9'h147, 9'h149,
    9'h153, 9'h14f, 9'h151, 9'h14d, 9'h14b, 9'h150, 9'h148, 9'h045,
    9'h135, 9'h037, 9'h04a, 9'h04e, 9'h11c, 9'h04f, 9'h050, 9'h051,
    9'h04b, 9'h04c, 9'h04d, 9'h047, 9'h048, 9'h049, 9'h052, 9'h053
  };

  localparam logic [8:0] ModRom [NumMods] = '{
    9'h01d, 9'h02a, 9'h038, 9'h15b, 9'h11d, 9'h036, 9'h138, 9'h15c
  };

  typedef logic [NumSlots-1:0][7:0] key_set_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } report_t;

  typedef struct packed {
    logic [7:0] scancode;
    logic       extended;
    logic       last_of_run;
  } scan_t;

  typedef struct packed {
    logic       ext;
    logic [7:0] code;
  } event_t;

  typedef struct packed {
    logic                 hit;
    logic                 ext;
    logic [7:0]           code;
  } lookup_t;

  // Pending scancodes of one report: a mask of live events and their codes
  typedef struct packed {
    logic [NumEvents-1:0]              mask;
    logic [NumEvents-1:0][8:0]         ev;
  } job_t;

  function automatic lookup_t usage_lookup(logic [7:0] usage);
    lookup_t    r;
    logic [7:0] idx;
    r   = '0;
    idx = usage - RomFirst;
    if (usage >= RomFirst && usage <= RomLast) begin
      r.hit  = 1'b1;
      r.ext  = UsageRom[idx[6:0]][8];
      r.code = UsageRom[idx[6:0]][7:0];
    end
    return r;
  endfunction

  function automatic logic set_holds(key_set_t set, logic [7:0] usage);
    logic found;
    found = 1'b0;
    for (int k = 0; k < NumSlots; k++) begin
      if (set[k] == usage) found = 1'b1;
    end
    return found;
  endfunction

endpackage

// ===== sv/hidks1_front.sv =====
module hidks1_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hidks1_pkg::report_t in_data_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output hidks1_pkg::job_t    push_data_o
);

  logic [7:0]           prev_mods_q;
  hidks1_pkg::key_set_t prev_keys_q;
  hidks1_pkg::key_set_t keys;
  logic [7:0]           mods;
  logic                 rollover;
  logic                 accept;
  hidks1_pkg::job_t     job;
  hidks1_pkg::lookup_t  rel_lu [hidks1_pkg::NumSlots];
  hidks1_pkg::lookup_t  prs_lu [hidks1_pkg::NumSlots];

  // Unpack the report into a slot array
  always_comb begin
    mods    = in_data_i.modifier_bits;
    keys[0] = in_data_i.key_slot_0;
    keys[1] = in_data_i.key_slot_1;
    keys[2] = in_data_i.key_slot_2;
    keys[3] = in_data_i.key_slot_3;
    keys[4] = in_data_i.key_slot_4;
    keys[5] = in_data_i.key_slot_5;
    rollover = keys[0] inside {[hidks1_pkg::ErrFirst:hidks1_pkg::ErrLast]};
  end

  // Classify every modifier change, release and press of this word
  always_comb begin
    job = '0;
    for (int i = 0; i < hidks1_pkg::NumMods; i++) begin
      job.mask[i] = mods[i] ^ prev_mods_q[i];
      job.ev[i]   = {hidks1_pkg::ModRom[i][8],
                     hidks1_pkg::ModRom[i][7:0] | (mods[i] ? 8'h00 : hidks1_pkg::BreakBit)};
    end
    for (int j = 0; j < hidks1_pkg::NumSlots; j++) begin
      rel_lu[j] = hidks1_pkg::usage_lookup(prev_keys_q[j]);
      prs_lu[j] = hidks1_pkg::usage_lookup(keys[j]);
      job.mask[hidks1_pkg::RelBase + j] = rel_lu[j].hit &&
          !hidks1_pkg::set_holds(keys, prev_keys_q[j]);
      job.ev[hidks1_pkg::RelBase + j]   = {rel_lu[j].ext,
                                           rel_lu[j].code | hidks1_pkg::BreakBit};
      job.mask[hidks1_pkg::PressBase + j] = prs_lu[j].hit &&
          !hidks1_pkg::set_holds(prev_keys_q, keys[j]);
      job.ev[hidks1_pkg::PressBase + j]   = {prs_lu[j].ext, prs_lu[j].code};
    end
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && in_ready_o && !rollover;
  assign push_valid_o = in_valid_i && !rollover && (|job.mask);
  assign push_data_o  = job;

  // Take the report as the new state; drop rollover words untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else if (accept) begin
      prev_mods_q <= mods;
      prev_keys_q <= keys;
    end
  end

endmodule

// ===== sv/hidks1_queue.sv =====
module hidks1_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  hidks1_pkg::job_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output hidks1_pkg::job_t pop_data_o
);

  hidks1_pkg::job_t store_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Hold pending jobs
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ===== sv/hidks1_back.sv =====
module hidks1_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  hidks1_pkg::job_t  pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hidks1_pkg::scan_t out_data_o
);

  logic                                busy_q;
  logic [hidks1_pkg::NumEvents-1:0]      mask_q;
  logic [hidks1_pkg::NumEvents-1:0][8:0] ev_q;
  logic                                out_valid_q;
  hidks1_pkg::scan_t                   out_q;
  logic [hidks1_pkg::EvIdxW-1:0]       sel;
  logic [hidks1_pkg::NumEvents-1:0]      first;
  logic [hidks1_pkg::NumEvents-1:0]      rest;
  logic                                emit;
  hidks1_pkg::event_t                  ev_sel;

  // Pick the lowest pending event
  always_comb begin
    sel = '0;
    for (int i = hidks1_pkg::NumEvents - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = hidks1_pkg::EvIdxW'(i);
    end
    first  = mask_q & (~mask_q + 1'b1);
    rest   = mask_q & ~first;
    ev_sel = ev_q[sel];
  end

  assign emit        = busy_q && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Load a job, then send one word per cycle while the output is not stalled, until its mask is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && pop_valid_i) begin
        busy_q <= 1'b1;
        mask_q <= pop_data_i.mask;
      end else if (emit) begin
        mask_q <= rest;
        busy_q <= (rest != '0);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold codes and the output word
  always_ff @(posedge clk_i) begin
    if (!busy_q && pop_valid_i) begin
      ev_q <= pop_data_i.ev;
    end
    if (emit) begin
      out_q.scancode    <= ev_sel.code;
      out_q.extended    <= ev_sel.ext;
      out_q.last_of_run <= (rest == '0);
    end
  end

endmodule

// ===== sv/hid_report_to_set1_scancodes_core.sv =====
// Translates USB HID boot keyboard reports into Set 1 scancodes. Each report
// word is classified against the previous report in the cycle it is taken:
// changed modifiers, released keys and pressed keys become one job in a
// two-deep queue, and rollover-error reports are dropped without touching the
// stored state. The emitter loads a job and then sends one scancode per
// cycle while the output is not stalled, taking no new job until the last
// one is sent; a report yields at most 20 scancodes, and a report with no
// changes makes no job and sends nothing. The input accepts a new report
// whenever the queue has room, and last_of_run marks the final scancode of each report.
module hid_report_to_set1_scancodes_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hidks1_pkg::report_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hidks1_pkg::scan_t   out_data_o
);

  logic             push_valid;
  logic             push_ready;
  hidks1_pkg::job_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  hidks1_pkg::job_t pop_data;

  hidks1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  hidks1_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hidks1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/hidks1_checker.sv =====
module hidks1_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hidks1_pkg::scan_t out_data_o
);

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // No word leaves in the first cycle after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight out of reset");

  // Every translated code is a real make or break code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.scancode[6:0] != 7'h00)
    else $error("empty scancode emitted");

  // An offered output word carries known bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_data_o))
    else $error("unknown bits in output word");

  // The input side always answers an offered word with a known ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_ready_o))
    else $error("unknown input ready");

endmodule

bind hid_report_to_set1_scancodes_core hidks1_checker u_checker (.*);
